// ===== rtl/drft_pkg.sv =====
// drft_pkg: shared types, codes and defaults for the dirty region frame tracker.
// No dependencies; used by rtl/dirty_region_frame_tracker.sv.
package drft_pkg;

  localparam int MAX_DEPTH_DEF  = 255;
  localparam int COORD_BITS_DEF = 12;

  localparam int CMD_W    = 2;
  localparam int IN_W     = 16;
  localparam int STATUS_W = 2;
  localparam int OUT_POS_W = 12;
  localparam int OUT_DIM_W = 13;
  localparam int DEPTH_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int SCR_W    = 13;

  localparam logic [SCR_W-1:0] SCREEN_W_RST = 13'd640;
  localparam logic [SCR_W-1:0] SCREEN_H_RST = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE_VALID   = 2'd0,
    REG_BACKBUFFER   = 2'd1,
    REG_SCREEN_WIDTH = 2'd2,
    REG_SCREEN_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_END   = 2'd2,
    CMD_FLIP  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE      = 2'd0,
    ST_COPY      = 2'd1,
    ST_UNMATCHED = 2'd2,
    ST_FLIP_IGN  = 2'd3
  } status_t;

endpackage

// ===== rtl/dirty_region_frame_tracker.sv =====
// dirty_region_frame_tracker: frame nesting and dirty bounding box.
// Depends on rtl/drft_pkg.sv.
//
// channel  direction  handshake               payload
// in_      input      in_valid / in_stall     in_cmd, in_x_pos, in_y_pos, in_width_in, in_height_in
// out_     output     out_valid / out_stall   out_status, out_copy_*, out_open_depth
// cfg_     input      cfg_we                  cfg_index, cfg_wdata
//
// One item per cycle while out_stall is low; each item passes the input register, then
// the clip/merge logic into the result register, and leaves it while out_stall is low.
// Synchronous active-low reset restores register defaults and clears depth and box valid.
// out_stall holds a valid result register and, when the input register is also full,
// raises in_stall in the same cycle.
module dirty_region_frame_tracker #(
  parameter int MAX_DEPTH  = drft_pkg::MAX_DEPTH_DEF,
  parameter int COORD_BITS = drft_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [drft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drft_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [drft_pkg::CMD_W-1:0]      in_cmd,
  input  logic [drft_pkg::IN_W-1:0]       in_x_pos,
  input  logic [drft_pkg::IN_W-1:0]       in_y_pos,
  input  logic [drft_pkg::IN_W-1:0]       in_width_in,
  input  logic [drft_pkg::IN_W-1:0]       in_height_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [drft_pkg::STATUS_W-1:0]   out_status,
  output logic [drft_pkg::OUT_POS_W-1:0]  out_copy_x,
  output logic [drft_pkg::OUT_POS_W-1:0]  out_copy_y,
  output logic [drft_pkg::OUT_DIM_W-1:0]  out_copy_width,
  output logic [drft_pkg::OUT_DIM_W-1:0]  out_copy_height,
  output logic [drft_pkg::DEPTH_W-1:0]    out_open_depth
);

  // effective screen dimension is min(register, 2^COORD_BITS)
  localparam int SCR_W = drft_pkg::SCR_W;
  localparam int DIM_W = (COORD_BITS < SCR_W) ? COORD_BITS + 1 : SCR_W;
  localparam int POS_W = (COORD_BITS < SCR_W) ? COORD_BITS : SCR_W;
  localparam int LIM   = 1 << COORD_BITS;
  localparam int CMP_W = drft_pkg::IN_W + 1;
  localparam int DW    = drft_pkg::DEPTH_W;
  localparam logic [DW-1:0] DEPTH_CAP = (MAX_DEPTH < 255) ? DW'(MAX_DEPTH) : DW'(255);

  // configuration
  logic             mode_valid_r, backbuffer_r;
  logic [SCR_W-1:0] screen_w_r, screen_h_r;

  // tracker state
  logic [DW-1:0]    depth_r, depth_nxt;
  logic             box_valid_r, box_valid_nxt;
  logic [POS_W-1:0] box_left_r, box_left_nxt, box_top_r, box_top_nxt;
  logic [DIM_W-1:0] box_w_r, box_w_nxt, box_h_r, box_h_nxt;

  // input register
  logic                          s1_v_r;
  drft_pkg::cmd_t                s1_cmd_r;
  logic [drft_pkg::IN_W-1:0]     s1_x_r, s1_y_r, s1_w_r, s1_h_r;

  // result register
  logic                          out_v_r;
  drft_pkg::status_t             res_status_r, res_status_nxt;
  logic [drft_pkg::OUT_POS_W-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic [drft_pkg::OUT_DIM_W-1:0] res_w_r, res_w_nxt, res_h_r, res_h_nxt;
  logic [DW-1:0]                 res_depth_r;

  logic s1_go, in_accept;

  logic [DIM_W-1:0] sw_eff, sh_eff;
  logic             rect_ok, boxc_ok;
  logic [DIM_W-1:0] rect_cw, rect_ch, boxc_cw, boxc_ch;
  logic [POS_W-1:0] rx, ry, ml, mt;
  logic [DIM_W-1:0] mr, mb, orr, ob;

  function automatic logic clip_ok(input logic [drft_pkg::IN_W-1:0] x, y, w, h,
                                   input logic [DIM_W-1:0] sw, sh, input logic mode);
    return mode && (w != '0) && (h != '0) &&
           (CMP_W'(x) < CMP_W'(sw)) && (CMP_W'(y) < CMP_W'(sh));
  endfunction

  function automatic logic [DIM_W-1:0] clip_len(input logic [drft_pkg::IN_W-1:0] p, len,
                                                input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] rem;
    rem = lim - DIM_W'(p);
    return (CMP_W'(len) > CMP_W'(rem)) ? rem : DIM_W'(len);
  endfunction

  assign sw_eff = (32'(screen_w_r) > LIM) ? DIM_W'(LIM) : DIM_W'(screen_w_r);
  assign sh_eff = (32'(screen_h_r) > LIM) ? DIM_W'(LIM) : DIM_W'(screen_h_r);

  assign s1_go     = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall  = s1_v_r && !s1_go;
  assign in_accept = in_valid && !in_stall;

  // clip of the incoming rectangle
  assign rect_ok = clip_ok(s1_x_r, s1_y_r, s1_w_r, s1_h_r, sw_eff, sh_eff, mode_valid_r);
  assign rect_cw = clip_len(s1_x_r, s1_w_r, sw_eff);
  assign rect_ch = clip_len(s1_y_r, s1_h_r, sh_eff);
  assign rx      = POS_W'(s1_x_r);
  assign ry      = POS_W'(s1_y_r);

  // re-clip of the stored box for the outermost end
  assign boxc_ok = clip_ok(16'(box_left_r), 16'(box_top_r), 16'(box_w_r), 16'(box_h_r),
                           sw_eff, sh_eff, mode_valid_r);
  assign boxc_cw = clip_len(16'(box_left_r), 16'(box_w_r), sw_eff);
  assign boxc_ch = clip_len(16'(box_top_r), 16'(box_h_r), sh_eff);

  // union with the stored box
  assign ml  = (rx < box_left_r) ? rx : box_left_r;
  assign mt  = (ry < box_top_r) ? ry : box_top_r;
  assign mr  = DIM_W'(rx) + rect_cw;
  assign mb  = DIM_W'(ry) + rect_ch;
  assign orr = DIM_W'(box_left_r) + box_w_r;
  assign ob  = DIM_W'(box_top_r) + box_h_r;

  always_comb begin
    logic bv;
    depth_nxt      = depth_r;
    box_valid_nxt  = box_valid_r;
    box_left_nxt   = box_left_r;
    box_top_nxt    = box_top_r;
    box_w_nxt      = box_w_r;
    box_h_nxt      = box_h_r;
    res_status_nxt = drft_pkg::ST_NONE;
    res_x_nxt      = '0;
    res_y_nxt      = '0;
    res_w_nxt      = '0;
    res_h_nxt      = '0;
    bv             = box_valid_r;
    case (s1_cmd_r)
      drft_pkg::CMD_BEGIN, drft_pkg::CMD_MARK: begin
        if ((s1_cmd_r == drft_pkg::CMD_BEGIN) || (depth_r != '0)) begin
          if (s1_cmd_r == drft_pkg::CMD_BEGIN) begin
            if (depth_r == '0) begin
              bv = 1'b0;
            end
            if (depth_r < DEPTH_CAP) begin
              depth_nxt = depth_r + DW'(1);
            end
          end
          box_valid_nxt = bv;
          if (rect_ok) begin
            box_valid_nxt = 1'b1;
            if (!bv) begin
              box_left_nxt = rx;
              box_top_nxt  = ry;
              box_w_nxt    = rect_cw;
              box_h_nxt    = rect_ch;
            end else begin
              box_left_nxt = ml;
              box_top_nxt  = mt;
              box_w_nxt    = ((mr < orr) ? orr : mr) - DIM_W'(ml);
              box_h_nxt    = ((mb < ob) ? ob : mb) - DIM_W'(mt);
            end
          end
        end
      end
      drft_pkg::CMD_END: begin
        if (depth_r == '0) begin
          res_status_nxt = drft_pkg::ST_UNMATCHED;
        end else begin
          depth_nxt = depth_r - DW'(1);
          if ((depth_r == DW'(1)) && box_valid_r) begin
            box_valid_nxt = 1'b0;
            if (backbuffer_r && boxc_ok) begin
              res_status_nxt = drft_pkg::ST_COPY;
              res_x_nxt      = drft_pkg::OUT_POS_W'(box_left_r);
              res_y_nxt      = drft_pkg::OUT_POS_W'(box_top_r);
              res_w_nxt      = drft_pkg::OUT_DIM_W'(boxc_cw);
              res_h_nxt      = drft_pkg::OUT_DIM_W'(boxc_ch);
            end
          end
        end
      end
      drft_pkg::CMD_FLIP: begin
        if (depth_r != '0) begin
          res_status_nxt = drft_pkg::ST_FLIP_IGN;
        end else if (backbuffer_r && rect_ok) begin
          res_status_nxt = drft_pkg::ST_COPY;
          res_x_nxt      = drft_pkg::OUT_POS_W'(rx);
          res_y_nxt      = drft_pkg::OUT_POS_W'(ry);
          res_w_nxt      = drft_pkg::OUT_DIM_W'(rect_cw);
          res_h_nxt      = drft_pkg::OUT_DIM_W'(rect_ch);
        end
      end
      default: begin
        res_status_nxt = drft_pkg::ST_NONE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_valid_r <= 1'b0;
      backbuffer_r <= 1'b0;
      screen_w_r   <= drft_pkg::SCREEN_W_RST;
      screen_h_r   <= drft_pkg::SCREEN_H_RST;
    end else if (cfg_we) begin
      case (drft_pkg::reg_idx_t'(cfg_index))
        drft_pkg::REG_MODE_VALID:    mode_valid_r <= cfg_wdata[0];
        drft_pkg::REG_BACKBUFFER:    backbuffer_r <= cfg_wdata[0];
        drft_pkg::REG_SCREEN_WIDTH:  screen_w_r   <= cfg_wdata;
        drft_pkg::REG_SCREEN_HEIGHT: screen_h_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      depth_r     <= '0;
      box_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        out_v_r     <= 1'b1;
        depth_r     <= depth_nxt;
        box_valid_r <= box_valid_nxt;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r <= drft_pkg::cmd_t'(in_cmd);
      s1_x_r   <= in_x_pos;
      s1_y_r   <= in_y_pos;
      s1_w_r   <= in_width_in;
      s1_h_r   <= in_height_in;
    end
    if (s1_go) begin
      box_left_r   <= box_left_nxt;
      box_top_r    <= box_top_nxt;
      box_w_r      <= box_w_nxt;
      box_h_r      <= box_h_nxt;
      res_status_r <= res_status_nxt;
      res_x_r      <= res_x_nxt;
      res_y_r      <= res_y_nxt;
      res_w_r      <= res_w_nxt;
      res_h_r      <= res_h_nxt;
      res_depth_r  <= depth_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_status      = res_status_r;
  assign out_copy_x      = res_x_r;
  assign out_copy_y      = res_y_r;
  assign out_copy_width  = res_w_r;
  assign out_copy_height = res_h_r;
  assign out_open_depth  = res_depth_r;

  // an open box always sits inside an open frame
  a_box_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    box_valid_r |-> (depth_r != '0))
    else $error("box valid with no frame open");

  // depth moves by at most one per item and stays at or under the cap
  a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> ((depth_r == $past(depth_r)) || (depth_r == $past(depth_r) + DW'(1)) ||
               (depth_r == $past(depth_r) - DW'(1))) && (depth_r <= DEPTH_CAP))
    else $error("depth step out of range");

  // a copy result carries a non-empty rectangle, any other result carries none
  a_copy_rect: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((res_status_r == drft_pkg::ST_COPY) ? ((res_w_r != '0) && (res_h_r != '0))
                 : ((res_x_r == '0) && (res_y_r == '0) && (res_w_r == '0) && (res_h_r == '0))))
    else $error("copy rectangle inconsistent with status");

  // the outermost end always leaves the box cleared
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && (s1_cmd_r == drft_pkg::CMD_END) && (depth_r == DW'(1))) |=> !box_valid_r)
    else $error("box survived outermost end");

endmodule
